// File: rtl/mi3_pkg.sv
// mi3_pkg: types, widths and index tables for the 3x3 matrix inverse
// no dependencies; every rtl file refers to it by scoped names
package mi3_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int NUM_ENT    = 9;
  // cofactor: difference of two full products
  localparam int COF_W      = 2 * DATA_WIDTH + 1;
  // determinant: sum of three entry-by-cofactor products
  localparam int DET_W      = 3 * DATA_WIDTH + 3;
  // magnitude of the determinant stays below 3 * 2^(3W-2)
  localparam int DMAG_W     = 3 * DATA_WIDTH;

  typedef logic [DATA_WIDTH-1:0] ent_t;
  typedef logic [COF_W-1:0]      cof_t;
  typedef logic [DET_W-1:0]      det_t;
  typedef logic [3:0]            eidx_t;

  localparam ent_t ENT_MAX     = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam ent_t ENT_MIN_MAG = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // adjugate entry k = e[a] * e[b] - e[c] * e[d], entries indexed row * 3 + col
  localparam eidx_t COF_IDX [NUM_ENT][4] = '{
    '{4'd4, 4'd8, 4'd7, 4'd5},
    '{4'd2, 4'd7, 4'd1, 4'd8},
    '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd5, 4'd6, 4'd3, 4'd8},
    '{4'd0, 4'd8, 4'd2, 4'd6},
    '{4'd3, 4'd2, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd6, 4'd4},
    '{4'd6, 4'd1, 4'd0, 4'd7},
    '{4'd0, 4'd4, 4'd3, 4'd1}
  };

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] m00;
    logic signed [DATA_WIDTH-1:0] m01;
    logic signed [DATA_WIDTH-1:0] m02;
    logic signed [DATA_WIDTH-1:0] m10;
    logic signed [DATA_WIDTH-1:0] m11;
    logic signed [DATA_WIDTH-1:0] m12;
    logic signed [DATA_WIDTH-1:0] m20;
    logic signed [DATA_WIDTH-1:0] m21;
    logic signed [DATA_WIDTH-1:0] m22;
  } mat_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] inv00;
    logic signed [DATA_WIDTH-1:0] inv01;
    logic signed [DATA_WIDTH-1:0] inv02;
    logic signed [DATA_WIDTH-1:0] inv10;
    logic signed [DATA_WIDTH-1:0] inv11;
    logic signed [DATA_WIDTH-1:0] inv12;
    logic signed [DATA_WIDTH-1:0] inv20;
    logic signed [DATA_WIDTH-1:0] inv21;
    logic signed [DATA_WIDTH-1:0] inv22;
    logic                         singular;
    logic                         saturated;
  } inv_t;

  typedef struct packed {
    ent_t [2:0]         row0;
    cof_t [NUM_ENT-1:0] cof;
  } cof_item_t;

  typedef struct packed {
    cof_t [NUM_ENT-1:0] cof;
    det_t               det;
  } det_item_t;

  typedef struct packed {
    ent_t [NUM_ENT-1:0] quo;
    logic [NUM_ENT-1:0] neg;
    logic [NUM_ENT-1:0] ovf;
    logic               dzero;
  } quo_item_t;

endpackage

// File: rtl/mi3_cofactor.sv
// mi3_cofactor: two-stage pipeline forming the nine adjugate cofactors
// depends on mi3_pkg
module mi3_cofactor (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_v,
  input  mi3_pkg::mat_t         in_mat,
  output logic                  rdy_o,
  output logic                  out_v,
  output mi3_pkg::cof_item_t    out_item,
  input  logic                  rdy_i
);

  localparam int W  = mi3_pkg::DATA_WIDTH;
  localparam int NE = mi3_pkg::NUM_ENT;

  typedef logic [2*W-1:0] prod_t;

  mi3_pkg::ent_t      e [NE];
  prod_t              prod_nxt [2*NE];
  prod_t              prod_r   [2*NE];
  mi3_pkg::ent_t [2:0] row0_nxt;
  mi3_pkg::ent_t [2:0] row0_r;
  mi3_pkg::cof_item_t item_nxt;
  mi3_pkg::cof_item_t item_r;
  logic               va_r, vb_r;
  logic               en_a, en_b;

  assign en_b  = !vb_r || rdy_i;
  assign en_a  = !va_r || en_b;
  assign rdy_o = en_a;

  always_comb begin
    e[0] = in_mat.m00;
    e[1] = in_mat.m01;
    e[2] = in_mat.m02;
    e[3] = in_mat.m10;
    e[4] = in_mat.m11;
    e[5] = in_mat.m12;
    e[6] = in_mat.m20;
    e[7] = in_mat.m21;
    e[8] = in_mat.m22;
    row0_nxt[0] = in_mat.m00;
    row0_nxt[1] = in_mat.m01;
    row0_nxt[2] = in_mat.m02;
  end

  // stage a: eighteen full signed products
  always_comb begin
    for (int k = 0; k < NE; k++) begin
      prod_nxt[2*k]   = prod_t'($signed(e[mi3_pkg::COF_IDX[k][0]]) *
                                $signed(e[mi3_pkg::COF_IDX[k][1]]));
      prod_nxt[2*k+1] = prod_t'($signed(e[mi3_pkg::COF_IDX[k][2]]) *
                                $signed(e[mi3_pkg::COF_IDX[k][3]]));
    end
  end

  // stage b: cofactor differences
  always_comb begin
    item_nxt.row0 = row0_r;
    for (int k = 0; k < NE; k++) begin
      item_nxt.cof[k] = mi3_pkg::cof_t'($signed(prod_r[2*k]) - $signed(prod_r[2*k+1]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (en_a) va_r <= in_v;
      if (en_b) vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      prod_r <= prod_nxt;
      row0_r <= row0_nxt;
    end
    if (en_b) item_r <= item_nxt;
  end

  assign out_v    = vb_r;
  assign out_item = item_r;

endmodule

// File: rtl/mi3_det.sv
// mi3_det: three-stage pipeline forming the exact determinant
// depends on mi3_pkg; each cofactor is split into a 32-bit low half and a 33-bit high half
module mi3_det (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_v,
  input  mi3_pkg::cof_item_t in_item,
  output logic               rdy_o,
  output logic               out_v,
  output mi3_pkg::det_item_t out_item,
  input  logic               rdy_i
);

  localparam int W = mi3_pkg::DATA_WIDTH;

  typedef logic [2*W:0] half_t;
  typedef logic [3*W:0] term_t;

  half_t                          hl_nxt [3];
  half_t                          hh_nxt [3];
  half_t                          hl_r   [3];
  half_t                          hh_r   [3];
  term_t                          term_nxt [3];
  term_t                          term_r   [3];
  mi3_pkg::cof_t [mi3_pkg::NUM_ENT-1:0] cof_c_r, cof_d_r;
  mi3_pkg::det_item_t             item_r;
  mi3_pkg::det_t                  det_nxt;
  logic                           vc_r, vd_r, ve_r;
  logic                           en_c, en_d, en_e;

  assign en_e  = !ve_r || rdy_i;
  assign en_d  = !vd_r || en_e;
  assign en_c  = !vc_r || en_d;
  assign rdy_o = en_c;

  // stage c: row 0 entry times low and high halves of its cofactor
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      hl_nxt[k] = half_t'($signed(in_item.row0[k]) *
                          $signed({1'b0, in_item.cof[3*k][W-1:0]}));
      hh_nxt[k] = half_t'($signed(in_item.row0[k]) *
                          $signed(in_item.cof[3*k][2*W:W]));
    end
  end

  // stage d: recombine halves
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      term_nxt[k] = term_t'(($signed(hh_r[k]) <<< W) + $signed(hl_r[k]));
    end
  end

  // stage e: sum of the three terms
  assign det_nxt = mi3_pkg::det_t'($signed(term_r[0]) + $signed(term_r[1]) +
                                   $signed(term_r[2]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
    end else begin
      if (en_c) vc_r <= in_v;
      if (en_d) vd_r <= vc_r;
      if (en_e) ve_r <= vd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_c) begin
      hl_r    <= hl_nxt;
      hh_r    <= hh_nxt;
      cof_c_r <= in_item.cof;
    end
    if (en_d) begin
      term_r  <= term_nxt;
      cof_d_r <= cof_c_r;
    end
    if (en_e) begin
      item_r.cof <= cof_d_r;
      item_r.det <= det_nxt;
    end
  end

  assign out_v    = ve_r;
  assign out_item = item_r;

endmodule

// File: rtl/mi3_divider.sv
// mi3_divider: nine-lane pipelined restoring divider, one quotient bit per stage
// depends on mi3_pkg; takes cofactors and determinant, gives magnitudes and signs
module mi3_divider (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_v,
  input  mi3_pkg::det_item_t in_item,
  output logic               rdy_o,
  output logic               out_v,
  output mi3_pkg::quo_item_t out_item,
  input  logic               rdy_i
);

  localparam int W     = mi3_pkg::DATA_WIDTH;
  localparam int F     = mi3_pkg::FRAC_BITS;
  localparam int NE    = mi3_pkg::NUM_ENT;
  localparam int DW    = mi3_pkg::DMAG_W;
  localparam int NUM_W = 2 * W + 2 * F;
  localparam int NS    = W + 2;

  typedef logic [2*W-1:0]  cmag_t;
  typedef logic [NUM_W-1:0] num_t;

  typedef struct packed {
    logic [NE-1:0][DW-1:0] rem;
    logic [NE-1:0][W-1:0]  quo;
    logic [NE-1:0][W-1:0]  low;
    logic [NE-1:0]         neg;
    logic [NE-1:0]         ovf;
    logic [DW-1:0]         dmag;
    logic                  dzero;
  } div_st_t;

  cmag_t         cmag_nxt [NE];
  cmag_t         cmag_r   [NE];
  logic [NE-1:0] csgn_nxt, csgn_r;
  logic [DW-1:0] dmag_nxt, dmag_r;
  logic          dsgn_r, dz_r;
  div_st_t       st_nxt [W+1];
  div_st_t       st_r   [W+1];
  logic [NS-1:0] v_r, v_nxt, en;

  // per-stage advance: a stage moves when empty or when the next one moves
  always_comb begin
    en[NS-1] = !v_r[NS-1] || rdy_i;
    for (int s = NS - 2; s >= 0; s--) begin
      en[s] = !v_r[s] || en[s+1];
    end
    v_nxt[0] = en[0] ? in_v : v_r[0];
    for (int s = 1; s < NS; s++) begin
      if (en[s]) v_nxt[s] = v_r[s-1];
      else       v_nxt[s] = v_r[s];
    end
  end

  assign rdy_o = en[0];

  // magnitudes and signs
  always_comb begin
    mi3_pkg::cof_t cabs;
    mi3_pkg::det_t dabs;
    for (int k = 0; k < NE; k++) begin
      csgn_nxt[k] = in_item.cof[k][mi3_pkg::COF_W-1];
      cabs = csgn_nxt[k] ? mi3_pkg::cof_t'(-$signed(in_item.cof[k])) : in_item.cof[k];
      cmag_nxt[k] = cabs[2*W-1:0];
    end
    dabs = in_item.det[mi3_pkg::DET_W-1] ? mi3_pkg::det_t'(-$signed(in_item.det))
                                          : in_item.det;
    dmag_nxt = dabs[DW-1:0];
  end

  // setup: overflow check and initial remainder, then one quotient bit per stage
  always_comb begin
    num_t                  num;
    logic [NUM_W-W-1:0]    init_rem;
    logic [DW:0]           r2;
    logic                  ge;
    st_nxt[0].dmag  = dmag_r;
    st_nxt[0].dzero = dz_r;
    for (int k = 0; k < NE; k++) begin
      num      = num_t'(cmag_r[k]) << (2 * F);
      init_rem = num[NUM_W-1:W];
      st_nxt[0].ovf[k] = (init_rem >= dmag_r);
      st_nxt[0].rem[k] = DW'(init_rem);
      st_nxt[0].low[k] = num[W-1:0];
      st_nxt[0].quo[k] = '0;
      st_nxt[0].neg[k] = csgn_r[k] ^ dsgn_r;
    end
    for (int s = 1; s <= W; s++) begin
      st_nxt[s] = st_r[s-1];
      for (int k = 0; k < NE; k++) begin
        r2 = {st_r[s-1].rem[k], st_r[s-1].low[k][W-1]};
        ge = (r2 >= {1'b0, st_r[s-1].dmag});
        st_nxt[s].rem[k] = ge ? DW'(r2 - {1'b0, st_r[s-1].dmag}) : r2[DW-1:0];
        st_nxt[s].quo[k] = {st_r[s-1].quo[k][W-2:0], ge};
        st_nxt[s].low[k] = {st_r[s-1].low[k][W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      cmag_r <= cmag_nxt;
      csgn_r <= csgn_nxt;
      dmag_r <= dmag_nxt;
      dsgn_r <= in_item.det[mi3_pkg::DET_W-1];
      dz_r   <= (in_item.det == '0);
    end
    for (int s = 0; s <= W; s++) begin
      if (en[s+1]) st_r[s] <= st_nxt[s];
    end
  end

  always_comb begin
    out_item.quo   = st_r[W].quo;
    out_item.neg   = st_r[W].neg;
    out_item.ovf   = st_r[W].ovf;
    out_item.dzero = st_r[W].dzero;
  end

  assign out_v = v_r[NS-1];

endmodule

// File: rtl/matrix_inverse_3x3.sv
// matrix_inverse_3x3: top level of the pipelined 3x3 adjugate inverse
// depends on mi3_pkg, mi3_cofactor, mi3_det and mi3_divider
//
// usage:
//   in channel:  in_valid / in_stall / in_item (nine signed Q16.16 entries).
//   out channel: out_valid / out_stall / out_item (nine inverse entries plus
//   singular and saturated flags). an item moves on a clock edge where valid
//   is high and stall is low.
// pipeline: 2 cofactor stages, 3 determinant stages, 2 divider setup stages,
//   32 divider bit stages and 1 output register.
// throughput: one item per cycle while out_stall is low; the 32-stage bit-serial divider
//   with nine lanes in parallel sets the depth, each stage a 97-bit compare and subtract.
// stall: each stage holds while the one after it is full and held, so empty
//   stages keep filling while a result waits; in_stall rises only once the
//   whole pipeline is full behind a stalled output.
// singular matrix: all entries zero, singular high, saturated low.
// reset: synchronous, active low; clears every valid bit, no items survive.
module matrix_inverse_3x3 (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  mi3_pkg::mat_t   in_item,
  output logic            out_valid,
  input  logic            out_stall,
  output mi3_pkg::inv_t   out_item
);

  localparam int W  = mi3_pkg::DATA_WIDTH;
  localparam int NE = mi3_pkg::NUM_ENT;

  mi3_pkg::cof_item_t cof_item;
  mi3_pkg::det_item_t det_item;
  mi3_pkg::quo_item_t quo_item;
  logic               cof_v, det_v, quo_v;
  logic               cof_rdy, det_rdy, quo_rdy, out_rdy;
  mi3_pkg::ent_t      res [NE];
  logic [NE-1:0]      sat_lane;
  mi3_pkg::inv_t      out_nxt;
  mi3_pkg::inv_t      out_r;
  logic               out_valid_r;

  // cofactors of the adjugate
  mi3_cofactor u_cof (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (in_valid),
    .in_mat   (in_item),
    .rdy_o    (cof_rdy),
    .out_v    (cof_v),
    .out_item (cof_item),
    .rdy_i    (det_rdy)
  );

  // determinant by expansion along row 0
  mi3_det u_det (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (cof_v),
    .in_item  (cof_item),
    .rdy_o    (det_rdy),
    .out_v    (det_v),
    .out_item (det_item),
    .rdy_i    (quo_rdy)
  );

  // nine quotients cofactor * 2^(2F) / det
  mi3_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (det_v),
    .in_item  (det_item),
    .rdy_o    (quo_rdy),
    .out_v    (quo_v),
    .out_item (quo_item),
    .rdy_i    (out_rdy)
  );

  assign in_stall = !cof_rdy;
  assign out_rdy  = !out_valid_r || !out_stall;

  // saturate to the signed entry range and apply the sign; all entries zero when det is zero
  always_comb begin
    mi3_pkg::ent_t lim;
    mi3_pkg::ent_t mag;
    for (int k = 0; k < NE; k++) begin
      lim = quo_item.neg[k] ? mi3_pkg::ENT_MIN_MAG : mi3_pkg::ENT_MAX;
      sat_lane[k] = quo_item.ovf[k] || (quo_item.quo[k] > lim);
      mag = sat_lane[k] ? lim : quo_item.quo[k];
      if (quo_item.dzero)      res[k] = '0;
      else if (quo_item.neg[k]) res[k] = W'(-mag);
      else                      res[k] = mag;
    end
    out_nxt.inv00     = res[0];
    out_nxt.inv01     = res[1];
    out_nxt.inv02     = res[2];
    out_nxt.inv10     = res[3];
    out_nxt.inv11     = res[4];
    out_nxt.inv12     = res[5];
    out_nxt.inv20     = res[6];
    out_nxt.inv21     = res[7];
    out_nxt.inv22     = res[8];
    out_nxt.singular  = quo_item.dzero;
    out_nxt.saturated = !quo_item.dzero && (|sat_lane);
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_rdy) begin
      out_valid_r <= quo_v;
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy) out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// File: rtl/mi3_checker.sv
// mi3_checker: port-level assertions for matrix_inverse_3x3
// depends on mi3_pkg; attached to the top level by the bind at the end
module mi3_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input mi3_pkg::inv_t out_item
);

  logic any_nz;
  logic hit_lim;

  always_comb begin
    any_nz = (out_item.inv00 != '0) || (out_item.inv01 != '0) || (out_item.inv02 != '0) ||
             (out_item.inv10 != '0) || (out_item.inv11 != '0) || (out_item.inv12 != '0) ||
             (out_item.inv20 != '0) || (out_item.inv21 != '0) || (out_item.inv22 != '0);
    hit_lim =
      (out_item.inv00 == mi3_pkg::ENT_MAX) || (out_item.inv00 == mi3_pkg::ENT_MIN_MAG) ||
      (out_item.inv01 == mi3_pkg::ENT_MAX) || (out_item.inv01 == mi3_pkg::ENT_MIN_MAG) ||
      (out_item.inv02 == mi3_pkg::ENT_MAX) || (out_item.inv02 == mi3_pkg::ENT_MIN_MAG) ||
      (out_item.inv10 == mi3_pkg::ENT_MAX) || (out_item.inv10 == mi3_pkg::ENT_MIN_MAG) ||
      (out_item.inv11 == mi3_pkg::ENT_MAX) || (out_item.inv11 == mi3_pkg::ENT_MIN_MAG) ||
      (out_item.inv12 == mi3_pkg::ENT_MAX) || (out_item.inv12 == mi3_pkg::ENT_MIN_MAG) ||
      (out_item.inv20 == mi3_pkg::ENT_MAX) || (out_item.inv20 == mi3_pkg::ENT_MIN_MAG) ||
      (out_item.inv21 == mi3_pkg::ENT_MAX) || (out_item.inv21 == mi3_pkg::ENT_MIN_MAG) ||
      (out_item.inv22 == mi3_pkg::ENT_MAX) || (out_item.inv22 == mi3_pkg::ENT_MIN_MAG);
  end

  // a held item stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("output item changed while stalled");

  // reset empties the pipeline and opens the input
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

  // singular gives all-zero entries and no saturation
  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.singular |-> !any_nz && !out_item.saturated)
    else $error("singular item with nonzero entries or saturation");

  // saturation shows up as a clipped entry
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.saturated |-> hit_lim)
    else $error("saturated item without a clipped entry");

endmodule

bind matrix_inverse_3x3 mi3_checker u_mi3_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

// File: test/matrix_inverse_3x3_tb.sv
// matrix_inverse_3x3_tb: self-checking testbench for the pipelined 3x3 inverse
// depends on mi3_pkg and matrix_inverse_3x3; exact-integer predictor, random idling
module matrix_inverse_3x3_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 80;
  localparam int ONE            = 1 << mi3_pkg::FRAC_BITS;

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_stall;
  mi3_pkg::mat_t  in_item;
  logic           out_valid;
  logic           out_stall;
  mi3_pkg::inv_t  out_item;

  mi3_pkg::inv_t pending_inverses[$];
  int    mismatch_count;
  int    idle_cycles;
  int    out_hold_left;
  bit    tx_steady;   // sender gaps disabled
  bit    rx_steady;   // receiver stalls disabled

  // cofactor index table: adjugate k = e[a]*e[b] - e[c]*e[d], entry index row*3+col
  int unsigned adj_terms [9][4] = '{
    '{4, 8, 7, 5}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{3, 2, 0, 5},
    '{3, 7, 6, 4}, '{6, 1, 0, 7}, '{0, 4, 3, 1}
  };

  string entry_names [9] = '{"inv00", "inv01", "inv02", "inv10", "inv11", "inv12",
                             "inv20", "inv21", "inv22"};

  matrix_inverse_3x3 dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // exact inverse: wide signed integers hold every cofactor and determinant
  function automatic mi3_pkg::inv_t exact_inverse(mi3_pkg::mat_t m);
    logic signed [127:0] e [9];
    logic signed [127:0] cof [9];
    logic signed [127:0] det;
    logic [127:0]        cmag;
    logic [127:0]        dmag;
    logic [127:0]        quo;
    logic [127:0]        lim;
    logic [31:0]         ent;
    logic                neg;
    mi3_pkg::inv_t       r;
    for (int k = 0; k < 9; k++) begin
      e[k] = $signed(m[32*(8-k) +: 32]);
    end
    for (int k = 0; k < 9; k++) begin
      cof[k] = e[adj_terms[k][0]] * e[adj_terms[k][1]]
             - e[adj_terms[k][2]] * e[adj_terms[k][3]];
    end
    // expansion along row 0 uses the first column of the adjugate
    det = e[0] * cof[0] + e[1] * cof[3] + e[2] * cof[6];
    r = '0;
    if (det == 0) begin
      r.singular = 1'b1;
      return r;
    end
    dmag = (det < 0) ? -det : det;
    for (int k = 0; k < 9; k++) begin
      cmag = (cof[k] < 0) ? -cof[k] : cof[k];
      neg  = (cof[k] < 0) != (det < 0);
      quo  = (cmag << (2 * mi3_pkg::FRAC_BITS)) / dmag;
      lim  = neg ? (128'd1 << 31) : ((128'd1 << 31) - 1);
      if (quo > lim) begin
        quo = lim;
        r.saturated = 1'b1;
      end
      ent = neg ? (~quo[31:0] + 32'd1) : quo[31:0];
      r[2 + 32*(8-k) +: 32] = ent;
    end
    return r;
  endfunction

  // input monitor: every accepted item queues its expected inverse
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      pending_inverses.push_back(exact_inverse(in_item));
    end
  end

  // receiver stall: a fresh hold is drawn after every accepted result unless the receiver is steady
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall     <= 1'b0;
      out_hold_left <= 0;
    end else if (out_valid && !out_stall) begin
      if (rx_steady) begin
        out_stall     <= 1'b0;
        out_hold_left <= 0;
      end else begin
        int draw;
        draw = $urandom_range(0, 16);
        out_stall     <= (draw > 0);
        out_hold_left <= (draw > 0) ? draw - 1 : 0;
      end
    end else if (out_hold_left > 0) begin
      out_stall     <= 1'b1;
      out_hold_left <= out_hold_left - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result checker: field by field against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      mi3_pkg::inv_t want;
      bit   bad;
      bad = 1'b0;
      if (pending_inverses.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result item %h", out_item);
      end else begin
        want = pending_inverses.pop_front();
        for (int k = 0; k < 9; k++) begin
          if (out_item[2 + 32*(8-k) +: 32] !== want[2 + 32*(8-k) +: 32]) begin
            bad = 1'b1;
            if (mismatch_count < 10)
              $display("%s mismatch: expected %h actual %h", entry_names[k],
                       want[2 + 32*(8-k) +: 32], out_item[2 + 32*(8-k) +: 32]);
          end
        end
        if (out_item.singular !== want.singular) begin
          bad = 1'b1;
          if (mismatch_count < 10)
            $display("singular mismatch: expected %b actual %b", want.singular,
                     out_item.singular);
        end
        if (out_item.saturated !== want.saturated) begin
          bad = 1'b1;
          if (mismatch_count < 10)
            $display("saturated mismatch: expected %b actual %b", want.saturated,
                     out_item.saturated);
        end
        if (bad) mismatch_count++;
      end
    end
  end

  // watchdog: counts cycles in which neither channel moves an item
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // send one matrix, with a random gap unless the sender is steady
  task automatic send_matrix(input mi3_pkg::mat_t m);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= m;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic mi3_pkg::mat_t diag(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    mi3_pkg::mat_t m;
    m = '0;
    m.m00 = a;
    m.m11 = b;
    m.m22 = c;
    return m;
  endfunction

  function automatic mi3_pkg::mat_t full_random_matrix();
    mi3_pkg::mat_t m;
    for (int k = 0; k < 9; k++) m[32*k +: 32] = $urandom;
    return m;
  endfunction

  // entries within +/- span, mostly modest determinants
  function automatic mi3_pkg::mat_t bounded_matrix(int span);
    mi3_pkg::mat_t m;
    for (int k = 0; k < 9; k++) m[32*k +: 32] = $urandom_range(0, 2 * span) - span;
    return m;
  endfunction

  task automatic test_special_matrices();
    mi3_pkg::mat_t m;
    send_matrix(diag(ONE, ONE, ONE));                     // identity
    send_matrix('0);                                       // zero matrix, singular
    send_matrix({9{32'h8000_0000}});                       // all most negative, singular
    send_matrix({9{32'h7fff_ffff}});                       // all max, singular
    send_matrix(diag(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    send_matrix(diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_matrix(diag(32'd1, 32'd1, 32'd1));                // tiny determinant, saturates
    send_matrix(diag(-32'sd1, 32'd1, 32'd1));              // negative saturation
    send_matrix(diag(2 * ONE, -4 * ONE, ONE / 2));
    send_matrix(diag(3 * ONE, 3 * ONE, 3 * ONE));          // inexact, truncation
    send_matrix(diag(-3 * ONE, 3 * ONE, 7 * ONE));
    m = '0;                                                // permutation, negative det
    m.m01 = ONE; m.m10 = ONE; m.m22 = ONE;
    send_matrix(m);
    m = bounded_matrix(4 * ONE);                           // duplicate row, singular
    m.m20 = m.m00; m.m21 = m.m01; m.m22 = m.m02;
    send_matrix(m);
    m = bounded_matrix(4 * ONE);                           // duplicate column, singular
    m.m02 = m.m01; m.m12 = m.m11; m.m22 = m.m21;
    send_matrix(m);
    m = diag(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff); // mixed extremes off diagonal
    m.m01 = 32'h8000_0000; m.m12 = 32'h7fff_ffff; m.m20 = 32'h0000_0001;
    send_matrix(m);
    send_matrix(diag(ONE, ONE, 32'd2));                    // saturation in one entry
    in_valid <= 1'b0;
  endtask

  // sender holds off until every expected inverse has come back
  task automatic test_drain_pause();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending_inverses.size() == 0);
    @(posedge clk);
  endtask

  task automatic test_random_matrices(int count);
    mi3_pkg::mat_t m;
    int   kind;
    for (int n = 0; n < count; n++) begin
      // steady stretches let the pipeline run at full rate
      if (n % 200 == 0) begin
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
      end
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2: m = full_random_matrix();
        3, 4:    m = bounded_matrix(8 * ONE);
        5:       m = bounded_matrix(64);
        6: begin
          m = bounded_matrix(16 * ONE);
          m.m10 = m.m00; m.m11 = m.m01; m.m12 = m.m02;
        end
        7:       m = diag($urandom_range(1, 4) , $urandom, $urandom_range(0, 3 * ONE));
        8: begin
          m = full_random_matrix();
          m.m00 = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
        end
        default: m = bounded_matrix(2);
      endcase
      send_matrix(m);
    end
    in_valid  <= 1'b0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_item        = '0;
    mismatch_count = 0;
    tx_steady      = 1'b0;
    rx_steady      = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_special_matrices();
    test_drain_pause();
    test_random_matrices(950);
    test_drain_pause();
    test_random_matrices(950);

    wait (pending_inverses.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// File: files.f
rtl/mi3_pkg.sv
rtl/mi3_cofactor.sv
rtl/mi3_det.sv
rtl/mi3_divider.sv
rtl/matrix_inverse_3x3.sv
rtl/mi3_checker.sv
test/matrix_inverse_3x3_tb.sv
